// ===== rtl/ua64_pkg.sv =====
// Package for the 64-bit unsigned arithmetic unit.
// Holds the data widths, the command codes and the handoff struct.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package ua64_pkg;

  // Operand and result width.
  localparam int DataW = 64;
  // The shared adder works on one extra bit so that it can take a shifted remainder.
  localparam int AluW  = DataW + 1;
  // The iteration counter covers one step per operand bit.
  localparam int CntW  = $clog2(DataW);
  localparam logic [CntW-1:0] CntLast = CntW'(DataW - 1);
  localparam int CmdW  = 2;

  typedef logic [DataW-1:0] ua64_data_t;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } ua64_cmd_e;

  // A finished result that waits in the sequencer for the output register.
  typedef struct packed {
    logic       valid;
    ua64_data_t result;
  } ua64_done_t;

endpackage : ua64_pkg

`default_nettype wire

// ===== rtl/ua64_cmd_if.sv =====
// Command channel of the arithmetic unit: command and two operands.
// Depends on ua64_pkg for the widths.
`default_nettype none

interface ua64_cmd_if;
  import ua64_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  ua64_data_t      operand_a;
  ua64_data_t      operand_b;

  modport source (output valid, output command, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input command, input operand_a, input operand_b,
                  output ready);
endinterface : ua64_cmd_if

`default_nettype wire

// ===== rtl/ua64_res_if.sv =====
// Result channel of the arithmetic unit: one 64-bit result per beat.
// Depends on ua64_pkg for the width.
`default_nettype none

interface ua64_res_if;
  import ua64_pkg::*;

  logic       valid;
  logic       ready;
  ua64_data_t result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface : ua64_res_if

`default_nettype wire

// ===== rtl/ua64_alu.sv =====
// Shared adder/subtractor of the arithmetic unit.
// One 65-bit add or subtract per cycle; the carry out flags x >= y on subtract.
// Depends on ua64_pkg.
`default_nettype none

module ua64_alu (
  input  wire logic [ua64_pkg::AluW-1:0] x_i,
  input  wire logic [ua64_pkg::AluW-1:0] y_i,
  input  wire logic                      sub_i,
  output logic      [ua64_pkg::AluW-1:0] sum_o,
  output logic                           carry_o
);
  import ua64_pkg::*;

  logic [AluW-1:0] y_inv;

  // Subtraction is addition of the inverted operand plus one.
  assign y_inv = y_i ^ {AluW{sub_i}};
  assign {carry_o, sum_o} = {1'b0, x_i} + {1'b0, y_inv} + {{AluW{1'b0}}, sub_i};

endmodule : ua64_alu

`default_nettype wire

// ===== rtl/ua64_ctrl.sv =====
// Sequencer and working registers of the arithmetic unit.
// Drives the shared adder once per cycle for add, subtract, multiply and divide.
// Depends on ua64_pkg, ua64_cmd_if and ua64_alu.
`default_nettype none

module ua64_ctrl (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  ua64_cmd_if.sink        cmd_i,
  input  wire logic       take_i,
  output ua64_pkg::ua64_done_t done_o
);
  import ua64_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e          state_q, state_d;
  ua64_cmd_e       cmd_q, cmd_d;
  ua64_data_t      a_q, a_d;
  ua64_data_t      b_q, b_d;
  ua64_data_t      acc_q, acc_d;
  ua64_data_t      res_q, res_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [AluW-1:0] alu_x;
  logic [AluW-1:0] alu_y;
  logic            alu_sub;
  logic [AluW-1:0] alu_sum;
  logic            alu_carry;
  ua64_cmd_e       in_cmd;
  ua64_data_t      quot_next;

  assign in_cmd = ua64_cmd_e'(cmd_i.command);
  assign cmd_i.ready = (state_q == ST_IDLE);

  // Operand selection for the shared unit. In divide, acc holds the partial
  // remainder and a shifts the dividend out at the top and the quotient in.
  always_comb begin
    alu_x   = {1'b0, a_q};
    alu_y   = {1'b0, b_q};
    alu_sub = 1'b0;
    case (cmd_q)
      CMD_ADD: begin
        alu_sub = 1'b0;
      end
      CMD_SUB: begin
        alu_sub = 1'b1;
      end
      CMD_MUL: begin
        alu_x = {1'b0, acc_q};
        alu_y = {1'b0, (b_q[0] ? a_q : '0)};
      end
      CMD_DIV: begin
        alu_x   = {acc_q, a_q[DataW-1]};
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  ua64_alu u_alu (
    .x_i    (alu_x),
    .y_i    (alu_y),
    .sub_i  (alu_sub),
    .sum_o  (alu_sum),
    .carry_o(alu_carry)
  );

  assign quot_next = {a_q[DataW-2:0], alu_carry};

  // Next state and working registers.
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d = in_cmd;
          a_d   = cmd_i.operand_a;
          b_d   = cmd_i.operand_b;
          acc_d = '0;
          cnt_d = '0;
          // A zero divisor or a zero dividend gives a zero quotient at once.
          if (in_cmd == CMD_DIV && (cmd_i.operand_a == '0 || cmd_i.operand_b == '0)) begin
            res_d   = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        case (cmd_q)
          CMD_MUL: begin
            acc_d = alu_sum[DataW-1:0];
            a_d   = a_q << 1;
            b_d   = b_q >> 1;
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == CntLast) begin
              res_d   = alu_sum[DataW-1:0];
              state_d = ST_DONE;
            end
          end
          CMD_DIV: begin
            // Keep the difference when the divisor fits, else restore.
            acc_d = alu_carry ? alu_sum[DataW-1:0] : alu_x[DataW-1:0];
            a_d   = quot_next;
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == CntLast) begin
              res_d   = quot_next;
              state_d = ST_DONE;
            end
          end
          default: begin
            // Add and subtract finish in a single pass.
            res_d   = alu_sum[DataW-1:0];
            state_d = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= CMD_ADD;
      a_q     <= '0;
      b_q     <= '0;
      acc_q   <= '0;
      res_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      a_q     <= a_d;
      b_q     <= b_d;
      acc_q   <= acc_d;
      res_q   <= res_d;
      cnt_q   <= cnt_d;
    end
  end

  assign done_o.valid  = (state_q == ST_DONE);
  assign done_o.result = res_q;

  // Add and subtract reach the handoff after one pass through the run state.
  a_addsub_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready && (in_cmd == CMD_ADD || in_cmd == CMD_SUB))
      |-> ##2 done_o.valid)
    else $error("add/subtract result not ready two cycles after the beat");

  // A divide by zero gives zero on the next cycle.
  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready && in_cmd == CMD_DIV && cmd_i.operand_b == '0)
      |=> (done_o.valid && done_o.result == '0))
    else $error("divide by zero did not give a zero result");

  // A result that is not taken stays put.
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o.valid && !take_i) |=> (done_o.valid && $stable(done_o.result)))
    else $error("pending result changed before handoff");

  // The iteration counter is back at zero whenever the sequencer is idle.
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q == '0))
    else $error("iteration counter not cleared at idle");

endmodule : ua64_ctrl

`default_nettype wire

// ===== rtl/unsigned_64bit_arith_unit.sv =====
// Top level of the 64-bit unsigned arithmetic unit.
// Depends on ua64_pkg, ua64_cmd_if, ua64_res_if and ua64_ctrl.
//
// Usage:
//   cmd_i carries a command (0 add, 1 subtract, 2 multiply, 3 divide) and two
//   64-bit unsigned operands; res_o returns one 64-bit result per command beat.
//   Add and subtract wrap modulo 2^64, multiply returns the low 64 bits of the
//   product and divide returns the floor quotient (zero for a zero divisor or
//   a zero dividend).
// Sequencing:
//   One 65-bit adder is shared by all operations. Add and subtract use it once,
//   multiply and divide once per operand bit (64 passes). With the receiver
//   ready, a result goes from the sequencer's done state into the output
//   register, and res_o.valid rises once it is registered there; the zero
//   divide cases skip the run state. The unit takes one command at a time and
//   raises ready at the edge that hands its result to the output register.
// Reset and stalls:
//   Reset empties the sequencer and the output register. While the receiver
//   stalls, the output register holds its beat; the next command is still taken
//   and worked on, and its result waits in the sequencer until the register frees.
`default_nettype none

module unsigned_64bit_arith_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ua64_cmd_if.sink  cmd_i,
  ua64_res_if.source res_o
);
  import ua64_pkg::*;

  ua64_done_t done;
  logic       take;
  logic       out_valid_q, out_valid_d;
  ua64_data_t out_result_q, out_result_d;

  ua64_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_i),
    .take_i(take),
    .done_o(done)
  );

  // The output register loads when it is empty or being drained this cycle.
  assign take = done.valid && (!out_valid_q || res_o.ready);

  always_comb begin
    out_valid_d  = out_valid_q;
    out_result_d = out_result_q;
    if (take) begin
      out_valid_d  = 1'b1;
      out_result_d = done.result;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_result_q <= '0;
    end else begin
      out_valid_q  <= out_valid_d;
      out_result_q <= out_result_d;
    end
  end

  assign res_o.valid  = out_valid_q;
  assign res_o.result = out_result_q;

endmodule : unsigned_64bit_arith_unit

`default_nettype wire
